// File: src/toeq_pkg.sv
// Package for the time-ordered event queue: sizes, codes, the stored event
// record and the command and flag structs between controller and datapath.
// No dependencies.
`default_nettype none
package toeq_pkg;

  localparam int EVENT_SLOTS = 256;
  localparam int SLOT_W      = $clog2(EVENT_SLOTS);
  localparam int LINK_W      = $clog2(EVENT_SLOTS + 1);
  localparam int COUNT_W     = 9;
  localparam int TIME_W      = 32;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 3;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(EVENT_SLOTS);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_POP    = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_COUNT  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NONE    = 3'd2,
    ST_INVALID = 3'd3,
    ST_ALREADY = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_FREE,
    OP_TAKE,
    OP_RD_CUR,
    OP_ADV,
    OP_ADD_LINK,
    OP_ADD_PREV,
    OP_RM_UNLINK,
    OP_PUSH_CUR,
    OP_CNT_ADV,
    OP_POP,
    OP_FR_UNLINK,
    OP_PUSH_SLOT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_TAKE,
    S_ADD_CHK,
    S_ADD_EV,
    S_ADD_LINK,
    S_ADD_PREV,
    S_RM_CHK,
    S_RM_EV,
    S_RM_PUSH,
    S_POP_EV,
    S_FR_CHK,
    S_FR_EV,
    S_FR_PUSH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [15:0]       label;
    logic [31:0]       source;
    logic [9:0]        dest_slot;
    logic [31:0]       dest_id;
  } event_t;

  typedef struct packed {
    op_e     op;
    logic    res_we;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic              cur_end;
    logic              prev_end;
    logic              free_end;
    logic              time_gt;
    logic              time_lt;
    logic              match;
    logic              slot_hit;
    logic              slot_in_use;
    logic              slot_oob;
    logic              cnt_nz;
    logic              out_free;
    logic [KIND_W-1:0] kind;
  } flags_t;

endpackage
`default_nettype wire

// File: src/toeq_ctrl.sv
// Controller of the event queue: sequences list walks and updates.
// Depends on toeq_pkg; drives commands to toeq_dp and reads its flags.
`default_nettype none
module toeq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  toeq_pkg::flags_t flags_i,
  output toeq_pkg::cmd_t  cmd_o
);
  import toeq_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d           = state_q;
    st_d              = st_q;
    cmd_o.op          = OP_NONE;
    cmd_o.res_we      = 1'b0;
    cmd_o.res_status  = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_d    = ST_OK;
        state_d = S_DONE;
        case (flags_i.kind)
          KIND_ADD: begin
            if (flags_i.free_end) st_d = ST_FULL;
            else state_d = S_ADD_RD;
          end
          KIND_REMOVE, KIND_COUNT: state_d = S_RM_CHK;
          KIND_POP: begin
            if (flags_i.cur_end) begin
              st_d = ST_NONE;
            end else begin
              cmd_o.op = OP_RD_CUR;
              state_d  = S_POP_EV;
            end
          end
          KIND_FREE: begin
            if (flags_i.slot_oob) st_d = ST_INVALID;
            else if (!flags_i.slot_in_use) st_d = ST_ALREADY;
            else state_d = S_FR_CHK;
          end
          default: st_d = ST_OK;
        endcase
      end
      S_ADD_RD: begin
        cmd_o.op = OP_RD_FREE;
        state_d  = S_ADD_TAKE;
      end
      S_ADD_TAKE: begin
        cmd_o.op = OP_TAKE;
        state_d  = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (flags_i.cur_end) begin
          state_d = S_ADD_LINK;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_ADD_EV;
        end
      end
      S_ADD_EV: begin
        if (flags_i.time_gt) begin
          cmd_o.op = OP_ADV;
          state_d  = S_ADD_CHK;
        end else begin
          state_d = S_ADD_LINK;
        end
      end
      S_ADD_LINK: begin
        cmd_o.op = OP_ADD_LINK;
        st_d     = ST_OK;
        state_d  = flags_i.prev_end ? S_DONE : S_ADD_PREV;
      end
      S_ADD_PREV: begin
        cmd_o.op = OP_ADD_PREV;
        state_d  = S_DONE;
      end
      S_RM_CHK: begin
        if (flags_i.cur_end) begin
          st_d    = flags_i.cnt_nz ? ST_OK : ST_NONE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_RM_EV;
        end
      end
      S_RM_EV: begin
        state_d = S_RM_CHK;
        if (flags_i.match && (flags_i.kind == KIND_REMOVE)) begin
          cmd_o.op = OP_RM_UNLINK;
          state_d  = S_RM_PUSH;
        end else if (flags_i.match) begin
          cmd_o.op = OP_CNT_ADV;
        end else begin
          cmd_o.op = OP_ADV;
        end
      end
      S_RM_PUSH: begin
        cmd_o.op = OP_PUSH_CUR;
        state_d  = S_RM_CHK;
      end
      S_POP_EV: begin
        state_d = S_DONE;
        if (flags_i.time_lt) begin
          cmd_o.op = OP_POP;
          st_d     = ST_OK;
        end else begin
          st_d = ST_NONE;
        end
      end
      S_FR_CHK: begin
        if (flags_i.cur_end) begin
          state_d = S_FR_PUSH;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_FR_EV;
        end
      end
      S_FR_EV: begin
        if (flags_i.slot_hit) begin
          cmd_o.op = OP_FR_UNLINK;
          state_d  = S_FR_PUSH;
        end else begin
          cmd_o.op = OP_ADV;
          state_d  = S_FR_CHK;
        end
      end
      S_FR_PUSH: begin
        cmd_o.op = OP_PUSH_SLOT;
        st_d     = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o.res_we = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/toeq_dp.sv
// Datapath of the event queue: slot memories, link memory, list pointers
// and the result register. Depends on toeq_pkg; driven by toeq_ctrl.
`default_nettype none
module toeq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  toeq_pkg::cmd_t                 cmd_i,
  output toeq_pkg::flags_t               flags_o,
  input  logic [toeq_pkg::KIND_W-1:0]    kind_i,
  input  logic [31:0]                    event_time_i,
  input  logic [15:0]                    label_i,
  input  logic [31:0]                    source_id_i,
  input  logic [9:0]                     dest_slot_i,
  input  logic [31:0]                    dest_id_i,
  input  logic [toeq_pkg::SLOT_W-1:0]    slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [toeq_pkg::STATUS_W-1:0]  status_o,
  output logic [toeq_pkg::SLOT_W-1:0]    slot_out_o,
  output logic [toeq_pkg::COUNT_W-1:0]   count_o,
  output logic [31:0]                    out_time_o,
  output logic [15:0]                    out_label_o,
  output logic [31:0]                    out_source_o,
  output logic [9:0]                     out_dest_slot_o,
  output logic [31:0]                    out_dest_id_o
);
  import toeq_pkg::*;

  // Stored events and links.
  event_t            ev_mem [EVENT_SLOTS];
  logic [LINK_W-1:0] link_mem [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] link_vld_q;
  logic [EVENT_SLOTS-1:0] in_use_q;

  event_t            ev_rd_q;
  logic [LINK_W-1:0] link_rd_q;

  logic [LINK_W-1:0] qhead_q, fhead_q, cur_q, prev_q, slot_q, nxt_q;
  logic [COUNT_W-1:0] cnt_q;
  event_t             item_q;
  logic [KIND_W-1:0]  kind_q;
  logic [SLOT_W-1:0]  fslot_q;

  logic [LINK_W-1:0] rd_addr;
  logic              link_we;
  logic [LINK_W-1:0] link_wa, link_wd;
  logic              ev_we;

  assign rd_addr = (cmd_i.op == OP_RD_FREE) ? fhead_q : cur_q;
  assign ev_we   = (cmd_i.op == OP_TAKE);

  always_comb begin
    link_we = 1'b0;
    link_wa = cur_q;
    link_wd = fhead_q;
    case (cmd_i.op)
      OP_ADD_LINK: begin
        link_we = 1'b1;
        link_wa = slot_q;
        link_wd = cur_q;
      end
      OP_ADD_PREV: begin
        link_we = 1'b1;
        link_wa = prev_q;
        link_wd = slot_q;
      end
      OP_RM_UNLINK, OP_FR_UNLINK: begin
        link_we = (prev_q != END_MARK);
        link_wa = prev_q;
        link_wd = link_rd_q;
      end
      OP_PUSH_CUR: begin
        link_we = 1'b1;
        link_wa = cur_q;
        link_wd = fhead_q;
      end
      OP_PUSH_SLOT: begin
        link_we = 1'b1;
        link_wa = {1'b0, fslot_q};
        link_wd = fhead_q;
      end
      default: link_we = 1'b0;
    endcase
  end

  // Memories: one write port each, registered read at rd_addr.
  always_ff @(posedge clk_i) begin
    if (ev_we) ev_mem[slot_q[SLOT_W-1:0]] <= item_q;
    if (link_we) link_mem[link_wa[SLOT_W-1:0]] <= link_wd;
    if (cmd_i.op == OP_RD_CUR) ev_rd_q <= ev_mem[rd_addr[SLOT_W-1:0]];
    if ((cmd_i.op == OP_RD_CUR) || (cmd_i.op == OP_RD_FREE)) begin
      // A link never written since reset reads as the next slot.
      link_rd_q <= link_vld_q[rd_addr[SLOT_W-1:0]] ? link_mem[rd_addr[SLOT_W-1:0]]
                                                   : rd_addr + LINK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      in_use_q   <= '0;
      qhead_q    <= END_MARK;
      fhead_q    <= '0;
    end else begin
      if (link_we) link_vld_q[link_wa[SLOT_W-1:0]] <= 1'b1;
      case (cmd_i.op)
        OP_TAKE: begin
          in_use_q[slot_q[SLOT_W-1:0]] <= 1'b1;
          fhead_q <= link_rd_q;
        end
        OP_ADD_LINK: if (prev_q == END_MARK) qhead_q <= slot_q;
        OP_RM_UNLINK, OP_FR_UNLINK: if (prev_q == END_MARK) qhead_q <= link_rd_q;
        OP_PUSH_CUR: begin
          in_use_q[cur_q[SLOT_W-1:0]] <= 1'b0;
          fhead_q <= cur_q;
        end
        OP_PUSH_SLOT: begin
          in_use_q[fslot_q] <= 1'b0;
          fhead_q <= {1'b0, fslot_q};
        end
        OP_POP: qhead_q <= link_rd_q;
        default: ;
      endcase
    end
  end

  // Walk registers and the captured item.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        kind_q          <= kind_i;
        item_q.ev_time  <= event_time_i;
        item_q.label    <= label_i;
        item_q.source   <= source_id_i;
        item_q.dest_slot <= dest_slot_i;
        item_q.dest_id  <= dest_id_i;
        fslot_q         <= slot_i;
        cur_q           <= qhead_q;
        prev_q          <= END_MARK;
        slot_q          <= fhead_q;
        cnt_q           <= '0;
      end
      OP_ADV: begin
        prev_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      OP_CNT_ADV: begin
        cnt_q  <= cnt_q + COUNT_W'(1);
        prev_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      OP_RM_UNLINK: begin
        cnt_q <= cnt_q + COUNT_W'(1);
        nxt_q <= link_rd_q;
      end
      OP_PUSH_CUR: cur_q <= nxt_q;
      default: ;
    endcase
  end

  logic out_valid_q;
  logic out_free;
  logic res_ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign res_ok   = (cmd_i.res_status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_we) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      status_o        <= cmd_i.res_status;
      slot_out_o      <= '0;
      count_o         <= '0;
      out_time_o      <= '0;
      out_label_o     <= '0;
      out_source_o    <= '0;
      out_dest_slot_o <= '0;
      out_dest_id_o   <= '0;
      case (kind_q)
        KIND_ADD:  if (res_ok) slot_out_o <= slot_q[SLOT_W-1:0];
        KIND_FREE: if (res_ok) slot_out_o <= fslot_q;
        KIND_REMOVE, KIND_COUNT: count_o <= cnt_q;
        KIND_POP: begin
          if (res_ok) begin
            slot_out_o      <= cur_q[SLOT_W-1:0];
            out_time_o      <= ev_rd_q.ev_time;
            out_label_o     <= ev_rd_q.label;
            out_source_o    <= ev_rd_q.source;
            out_dest_slot_o <= ev_rd_q.dest_slot;
            out_dest_id_o   <= ev_rd_q.dest_id;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  assign flags_o.cur_end     = (cur_q == END_MARK);
  assign flags_o.prev_end    = (prev_q == END_MARK);
  assign flags_o.free_end    = (fhead_q == END_MARK);
  assign flags_o.time_gt     = (item_q.ev_time > ev_rd_q.ev_time);
  assign flags_o.time_lt     = (ev_rd_q.ev_time < item_q.ev_time);
  assign flags_o.match       = (ev_rd_q.label == item_q.label) &&
                               (ev_rd_q.source == item_q.source);
  assign flags_o.slot_hit    = (cur_q == {1'b0, fslot_q});
  assign flags_o.slot_in_use = in_use_q[fslot_q];
  assign flags_o.slot_oob    = ({1'b0, fslot_q} >= END_MARK);
  assign flags_o.cnt_nz      = (cnt_q != '0);
  assign flags_o.out_free    = out_free;
  assign flags_o.kind        = kind_q;

endmodule
`default_nettype wire

// File: src/time_ordered_event_queue_top.sv
// Top level of the time-ordered event queue: controller plus datapath.
// Depends on toeq_pkg, toeq_ctrl and toeq_dp.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   input   | in        | in_valid_i/in_stall_o| kind, time, label, source,
//           |           |                      | dest_slot, dest_id, slot
//   result  | out       | out_valid_o/out_stall_i | status, slot_out, count,
//           |           |                      | out_time .. out_dest_id
//
// One word is taken at a time. Pop, free of a bad or idle slot, a full add
// and unknown kinds do not walk the list; add, remove, count and free of
// a queued slot walk the list with one read of the slot and link memories
// and one evaluation per visited event, plus a push onto the free list per
// removed event.
// Reset empties the queue at once:
// link valid bits make every slot read as linked to the next one, no sweep.
// A stalled result holds in the output register; the result of the next
// word waits until it is taken.
`default_nettype none
module time_ordered_event_queue_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [toeq_pkg::KIND_W-1:0]   kind_i,
  input  logic [31:0]                   event_time_i,
  input  logic [15:0]                   label_i,
  input  logic [31:0]                   source_id_i,
  input  logic [9:0]                    dest_slot_i,
  input  logic [31:0]                   dest_id_i,
  input  logic [toeq_pkg::SLOT_W-1:0]   slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [toeq_pkg::STATUS_W-1:0] status_o,
  output logic [toeq_pkg::SLOT_W-1:0]   slot_out_o,
  output logic [toeq_pkg::COUNT_W-1:0]  count_o,
  output logic [31:0]                   out_time_o,
  output logic [15:0]                   out_label_o,
  output logic [31:0]                   out_source_o,
  output logic [9:0]                    out_dest_slot_o,
  output logic [31:0]                   out_dest_id_o
);
  import toeq_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // The controller owns sequencing; the datapath owns all list state.
  toeq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  toeq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .flags_o         (flags),
    .kind_i          (kind_i),
    .event_time_i    (event_time_i),
    .label_i         (label_i),
    .source_id_i     (source_id_i),
    .dest_slot_i     (dest_slot_i),
    .dest_id_i       (dest_id_i),
    .slot_i          (slot_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .slot_out_o      (slot_out_o),
    .count_o         (count_o),
    .out_time_o      (out_time_o),
    .out_label_o     (out_label_o),
    .out_source_o    (out_source_o),
    .out_dest_slot_o (out_dest_slot_o),
    .out_dest_id_o   (out_dest_id_o)
  );

endmodule
`default_nettype wire
